// ===== sv/scf_pkg.sv =====
`timescale 1ns / 1ps

package scf_pkg;

    // Default limit on the number of frames one command may use.
    localparam int MAX_FRAMES_DEF = 4;

    // Configuration port geometry: eight 32-bit registers at 4*i.
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Payload buffer: the longest payload is 19 bytes. It is padded so that
    // the third chunk of seven bytes can be read without a range check.
    localparam int PAY_BYTES = 22;
    localparam int LEN_W     = 5;

    // Fixed payload bytes.
    localparam logic [7:0] CHECK_BYTE   = 8'h6B;
    localparam logic [7:0] FN_ENABLE    = 8'hF3;
    localparam logic [7:0] FN_SPEED     = 8'hF6;
    localparam logic [7:0] FN_POSITION  = 8'hFD;
    localparam logic [7:0] FN_STOP      = 8'hFE;
    localparam logic [7:0] FN_SYNC      = 8'hFF;
    localparam logic [7:0] FN_HOME      = 8'h9A;
    localparam logic [7:0] FN_HOME_PAR  = 8'h4C;
    localparam logic [7:0] SUB_ENABLE   = 8'hAB;
    localparam logic [7:0] SUB_STOP     = 8'h98;
    localparam logic [7:0] SUB_SYNC     = 8'h66;
    localparam logic [7:0] SUB_HOME_PAR = 8'hAE;

    // Command codes on the input channel.
    typedef enum logic [2:0] {
        CMD_ENABLE      = 3'd0,
        CMD_SPEED       = 3'd1,
        CMD_POSITION    = 3'd2,
        CMD_STOP        = 3'd3,
        CMD_SYNC        = 3'd4,
        CMD_HOME        = 3'd5,
        CMD_HOME_PARAMS = 3'd6
    } t_cmd;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_HOME_MODE    = 3'd0,
        REG_HOME_DIR     = 3'd1,
        REG_HOME_SPEED   = 3'd2,
        REG_HOME_TIMEOUT = 3'd3,
        REG_BUMP_SPEED   = 3'd4,
        REG_BUMP_CURRENT = 3'd5,
        REG_BUMP_TIME    = 3'd6,
        REG_AUTO_HOME    = 3'd7
    } t_reg_idx;

    // Homing parameters held in the configuration registers.
    typedef struct packed {
        logic [7:0]  home_mode_setting;
        logic [7:0]  home_direction;
        logic [15:0] home_speed_rpm;
        logic [31:0] home_timeout_ms;
        logic [15:0] bump_speed_rpm;
        logic [15:0] bump_current_ma;
        logic [15:0] bump_time_ms;
        logic        auto_home_on;
    } t_home_cfg;

endpackage

// ===== sv/scf_cmd_if.sv =====
`timescale 1ns / 1ps

interface scf_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [7:0]  addr;
    logic        enable_on;
    logic        ccw;
    logic [15:0] rpm;
    logic [7:0]  accel;
    logic [31:0] pulses;
    logic        absolute_move;
    logic        sync_flag;
    logic [7:0]  home_kind;
    logic        save_flag;

    modport source (
        output valid, command, addr, enable_on, ccw, rpm, accel, pulses,
               absolute_move, sync_flag, home_kind, save_flag,
        input  ready
    );

    modport sink (
        input  valid, command, addr, enable_on, ccw, rpm, accel, pulses,
               absolute_move, sync_flag, home_kind, save_flag,
        output ready
    );
endinterface

// ===== sv/scf_frame_if.sv =====
`timescale 1ns / 1ps

interface scf_frame_if;
    logic        valid;
    logic        ready;
    logic [15:0] can_id;
    logic [3:0]  frame_len;
    logic [63:0] frame_data;
    logic        last_frame;
    logic        too_large;

    modport source (
        output valid, can_id, frame_len, frame_data, last_frame, too_large,
        input  ready
    );

    modport sink (
        input  valid, can_id, frame_len, frame_data, last_frame, too_large,
        output ready
    );
endinterface

// ===== sv/scf_cfg_regs.sv =====
`timescale 1ns / 1ps

module scf_cfg_regs
    import scf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_home_cfg         o_cfg
);

    t_home_cfg r_cfg;
    logic      w_wr;
    t_reg_idx  w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign o_cfg  = r_cfg;

    // Register writes, each truncated to the register's width.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_HOME_MODE:    r_cfg.home_mode_setting <= pwdata[7:0];
                REG_HOME_DIR:     r_cfg.home_direction    <= pwdata[7:0];
                REG_HOME_SPEED:   r_cfg.home_speed_rpm    <= pwdata[15:0];
                REG_HOME_TIMEOUT: r_cfg.home_timeout_ms   <= pwdata[31:0];
                REG_BUMP_SPEED:   r_cfg.bump_speed_rpm    <= pwdata[15:0];
                REG_BUMP_CURRENT: r_cfg.bump_current_ma   <= pwdata[15:0];
                REG_BUMP_TIME:    r_cfg.bump_time_ms      <= pwdata[15:0];
                REG_AUTO_HOME:    r_cfg.auto_home_on      <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    // Read-back mux, zero-extended.
    always_comb begin
        case (w_idx)
            REG_HOME_MODE:    prdata = DATA_W'(r_cfg.home_mode_setting);
            REG_HOME_DIR:     prdata = DATA_W'(r_cfg.home_direction);
            REG_HOME_SPEED:   prdata = DATA_W'(r_cfg.home_speed_rpm);
            REG_HOME_TIMEOUT: prdata = DATA_W'(r_cfg.home_timeout_ms);
            REG_BUMP_SPEED:   prdata = DATA_W'(r_cfg.bump_speed_rpm);
            REG_BUMP_CURRENT: prdata = DATA_W'(r_cfg.bump_current_ma);
            REG_BUMP_TIME:    prdata = DATA_W'(r_cfg.bump_time_ms);
            REG_AUTO_HOME:    prdata = DATA_W'(r_cfg.auto_home_on);
            default:          prdata = '0;
        endcase
    end

endmodule

// ===== sv/stepper_command_can_framer.sv =====
`timescale 1ns / 1ps

// Stepper command CAN framer.
// Commands arrive on the i_cmd valid/ready channel; CAN frames leave on the
// o_frame valid/ready channel, one frame per beat. The homing parameters used
// by the write homing parameters command are set through the APB-style port,
// which must only be written while the block is idle.
// An accepted command is built into its byte payload in the input register
// stage. Its frames then move one per cycle, while the receiver does not
// stall, into the output register, so the first frame is valid once it has
// passed the command register and the output register. A command gives one
// frame for enable, speed, stop, sync start and trigger home, two for position
// and three for write homing parameters; the next command is accepted in the
// cycle its last frame moves to the output.
// Commands too large for MAX_FRAMES give one error beat; command code 7 is
// accepted and gives nothing.
// When the receiver stalls, the output register holds its frame and the
// emitter waits; i_cmd.ready drops once a command is waiting behind it.
// Synchronous reset clears both channels and all configuration registers;
// i_cmd.ready stays low while reset is held.
module stepper_command_can_framer
    import scf_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    scf_cmd_if.sink           i_cmd,
    scf_frame_if.source       o_frame
);

    localparam logic [3:0] MAX_FR = 4'(MAX_FRAMES);

    t_home_cfg w_cfg;

    // Built payload of the incoming command.
    logic [PAY_BYTES-1:0][7:0] w_pay;
    logic [LEN_W-1:0]          w_n;
    logic [1:0]                w_nfr;
    logic                      w_single;
    logic                      w_drop;
    logic [7:0]                w_addr;
    logic                      w_err;

    // Command held while its frames are emitted.
    logic                      r_busy;
    logic [PAY_BYTES-1:0][7:0] r_pay;
    logic [LEN_W-1:0]          r_n;
    logic [1:0]                r_nfr;
    logic [1:0]                r_fi;
    logic                      r_single;
    logic                      r_err;
    logic [7:0]                r_addr;

    // Output register.
    logic        r_ov;
    logic [15:0] r_can_id;
    logic [3:0]  r_len;
    logic [63:0] r_data;
    logic        r_last;
    logic        r_too_large;

    // Current frame.
    logic [15:0]      n_can_id;
    logic [3:0]       n_len;
    logic [63:0]      n_data;
    logic             n_last;
    logic [LEN_W-1:0] w_rem;
    logic [LEN_W-1:0] w_chunk;
    logic [55:0]      w_body;

    logic w_emit;
    logic w_acc;

    scf_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Payload builder: function byte, operands big endian, then the check byte.
    always_comb begin
        w_pay    = '0;
        w_n      = '0;
        w_nfr    = 2'd1;
        w_single = 1'b1;
        w_drop   = 1'b0;
        w_addr   = i_cmd.addr;
        case (t_cmd'(i_cmd.command))
            CMD_ENABLE: begin
                w_pay[0] = FN_ENABLE;
                w_pay[1] = SUB_ENABLE;
                w_pay[2] = 8'(i_cmd.enable_on);
                w_pay[3] = 8'(i_cmd.sync_flag);
                w_pay[4] = CHECK_BYTE;
                w_n      = LEN_W'(5);
            end
            CMD_SPEED: begin
                w_pay[0] = FN_SPEED;
                w_pay[1] = 8'(i_cmd.ccw);
                w_pay[2] = i_cmd.rpm[15:8];
                w_pay[3] = i_cmd.rpm[7:0];
                w_pay[4] = i_cmd.accel;
                w_pay[5] = 8'(i_cmd.sync_flag);
                w_pay[6] = CHECK_BYTE;
                w_n      = LEN_W'(7);
            end
            CMD_POSITION: begin
                w_pay[0]  = FN_POSITION;
                w_pay[1]  = 8'(i_cmd.ccw);
                w_pay[2]  = i_cmd.rpm[15:8];
                w_pay[3]  = i_cmd.rpm[7:0];
                w_pay[4]  = i_cmd.accel;
                w_pay[5]  = i_cmd.pulses[31:24];
                w_pay[6]  = i_cmd.pulses[23:16];
                w_pay[7]  = i_cmd.pulses[15:8];
                w_pay[8]  = i_cmd.pulses[7:0];
                w_pay[9]  = 8'(i_cmd.absolute_move);
                w_pay[10] = 8'(i_cmd.sync_flag);
                w_pay[11] = CHECK_BYTE;
                w_n       = LEN_W'(12);
                w_nfr     = 2'd2;
                w_single  = 1'b0;
            end
            CMD_STOP: begin
                w_pay[0] = FN_STOP;
                w_pay[1] = SUB_STOP;
                w_pay[2] = 8'(i_cmd.sync_flag);
                w_pay[3] = CHECK_BYTE;
                w_n      = LEN_W'(4);
            end
            CMD_SYNC: begin
                w_pay[0] = FN_SYNC;
                w_pay[1] = SUB_SYNC;
                w_pay[2] = CHECK_BYTE;
                w_n      = LEN_W'(3);
                w_addr   = 8'd0;
            end
            CMD_HOME: begin
                w_pay[0] = FN_HOME;
                w_pay[1] = i_cmd.home_kind;
                w_pay[2] = 8'(i_cmd.sync_flag);
                w_pay[3] = CHECK_BYTE;
                w_n      = LEN_W'(4);
            end
            CMD_HOME_PARAMS: begin
                w_pay[0]  = FN_HOME_PAR;
                w_pay[1]  = SUB_HOME_PAR;
                w_pay[2]  = 8'(i_cmd.save_flag);
                w_pay[3]  = w_cfg.home_mode_setting;
                w_pay[4]  = w_cfg.home_direction;
                w_pay[5]  = w_cfg.home_speed_rpm[15:8];
                w_pay[6]  = w_cfg.home_speed_rpm[7:0];
                w_pay[7]  = w_cfg.home_timeout_ms[31:24];
                w_pay[8]  = w_cfg.home_timeout_ms[23:16];
                w_pay[9]  = w_cfg.home_timeout_ms[15:8];
                w_pay[10] = w_cfg.home_timeout_ms[7:0];
                w_pay[11] = w_cfg.bump_speed_rpm[15:8];
                w_pay[12] = w_cfg.bump_speed_rpm[7:0];
                w_pay[13] = w_cfg.bump_current_ma[15:8];
                w_pay[14] = w_cfg.bump_current_ma[7:0];
                w_pay[15] = w_cfg.bump_time_ms[15:8];
                w_pay[16] = w_cfg.bump_time_ms[7:0];
                w_pay[17] = 8'(w_cfg.auto_home_on);
                w_pay[18] = CHECK_BYTE;
                w_n       = LEN_W'(19);
                w_nfr     = 2'd3;
                w_single  = 1'b0;
            end
            default: begin
                w_drop = 1'b1;
            end
        endcase
    end

    // A split payload that needs more frames than allowed becomes one error beat.
    assign w_err = !w_single && (4'(w_nfr) > MAX_FR);

    // Current frame: a short payload goes as is; a long one repeats the
    // function byte in front of each chunk of up to seven bytes.
    always_comb begin
        w_body = '0;
        w_rem  = '0;
        case (r_fi)
            2'd0: begin
                w_body = r_pay[7:1];
                w_rem  = r_n - LEN_W'(1);
            end
            2'd1: begin
                w_body = r_pay[14:8];
                w_rem  = r_n - LEN_W'(8);
            end
            2'd2: begin
                w_body = r_pay[21:15];
                w_rem  = r_n - LEN_W'(15);
            end
            default: begin
            end
        endcase
    end

    assign w_chunk = (w_rem > LEN_W'(7)) ? LEN_W'(7) : w_rem;

    always_comb begin
        if (r_err) begin
            n_can_id = '0;
            n_len    = '0;
            n_data   = '0;
            n_last   = 1'b1;
        end else if (r_single) begin
            n_can_id = {r_addr, 8'd0};
            n_len    = r_n[3:0];
            n_data   = r_pay[7:0];
            n_last   = 1'b1;
        end else begin
            n_can_id = {r_addr, 6'd0, r_fi};
            n_len    = w_chunk[3:0] + 4'd1;
            n_data   = {w_body, r_pay[0]};
            n_last   = (r_fi + 2'd1) == r_nfr;
        end
    end

    // Handshakes: a frame moves when the output register is free or drained.
    assign w_emit      = r_busy && (!r_ov || o_frame.ready);
    assign i_cmd.ready = i_rst_n && (!r_busy || (w_emit && n_last));
    assign w_acc       = i_cmd.valid && i_cmd.ready;

    // Command register and frame index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fi   <= '0;
        end else if (w_acc) begin
            r_busy <= !w_drop;
            r_fi   <= '0;
        end else if (w_emit) begin
            r_fi <= r_fi + 2'd1;
            if (n_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_pay    <= w_pay;
            r_n      <= w_n;
            r_nfr    <= w_nfr;
            r_single <= w_single;
            r_err    <= w_err;
            r_addr   <= w_addr;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_emit) begin
            r_ov <= 1'b1;
        end else if (o_frame.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_can_id    <= n_can_id;
            r_len       <= n_len;
            r_data      <= n_data;
            r_last      <= n_last;
            r_too_large <= r_err;
        end
    end

    assign o_frame.valid      = r_ov;
    assign o_frame.can_id     = r_can_id;
    assign o_frame.frame_len  = r_len;
    assign o_frame.frame_data = r_data;
    assign o_frame.last_frame = r_last;
    assign o_frame.too_large  = r_too_large;

endmodule

// ===== tb/stepper_command_can_framer_tb.sv =====
`timescale 1ns / 1ps

module stepper_command_can_framer_tb;
    import scf_pkg::*;

    parameter int MAX_FRAMES = MAX_FRAMES_DEF;

    // Unused command code, accepted by the block without any frame.
    localparam logic [2:0] CMD_NONE = 3'd7;

    localparam int      N_REGS          = 8;
    localparam int      N_PHASES        = 6;
    localparam int      ITEMS_PER_PHASE = 67;
    localparam int      DRAIN_GAP       = 8;
    localparam int      LONG_HOLD       = 150;
    localparam int      MAX_REPORTS     = 10;
    localparam longint  TIMEOUT_NS      = 4_000_000;

    // One command beat on the input channel.
    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  addr;
        logic        enable_on;
        logic        ccw;
        logic [15:0] rpm;
        logic [7:0]  accel;
        logic [31:0] pulses;
        logic        absolute_move;
        logic        sync_flag;
        logic [7:0]  home_kind;
        logic        save_flag;
    } t_cmd_beat;

    // One CAN frame beat on the output channel.
    typedef struct packed {
        logic [15:0] can_id;
        logic [3:0]  frame_len;
        logic [63:0] frame_data;
        logic        last_frame;
        logic        too_large;
    } t_frame;

    // A directed row: the command and, where typed, its single frame.
    typedef struct packed {
        t_cmd_beat beat;
        logic      typed;
        t_frame    frame;
    } t_dir_row;

    localparam t_frame NO_FRAME = '0;
    localparam int     N_DIR    = 20;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    scf_cmd_if   cmd_ch ();
    scf_frame_if frm_ch ();

    stepper_command_can_framer #(
        .MAX_FRAMES (MAX_FRAMES)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_cmd   (cmd_ch),
        .o_frame (frm_ch)
    );

    // Local copy of the homing registers, frames still owed by the block.
    t_home_cfg   home_cfg;
    t_frame      frames_due [$];
    t_frame      built_frames [8];
    int unsigned mismatches;
    bit          quiet;
    bit          hold_req;

    // Directed commands: extremes of every field and every command code.
    t_dir_row dir_rows [N_DIR] = '{
        '{'{CMD_ENABLE, 8'h00, 1'b0, 1'b0, 16'h0000, 8'h00, 32'h0, 1'b0, 1'b0, 8'h00, 1'b0},
          1'b1, '{16'h0000, 4'd5, 64'h0000_006B_0000_ABF3, 1'b1, 1'b0}},
        '{'{CMD_ENABLE, 8'hFF, 1'b1, 1'b1, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b1,
            8'hFF, 1'b1},
          1'b1, '{16'hFF00, 4'd5, 64'h0000_006B_0101_ABF3, 1'b1, 1'b0}},
        '{'{CMD_SPEED, 8'h01, 1'b0, 1'b1, 16'hFFFF, 8'hFF, 32'h0, 1'b0, 1'b1, 8'h00, 1'b0},
          1'b1, '{16'h0100, 4'd7, 64'h006B_01FF_FFFF_01F6, 1'b1, 1'b0}},
        '{'{CMD_SPEED, 8'h80, 1'b0, 1'b0, 16'h0000, 8'h00, 32'h0, 1'b0, 1'b0, 8'h00, 1'b0},
          1'b1, '{16'h8000, 4'd7, 64'h006B_0000_0000_00F6, 1'b1, 1'b0}},
        '{'{CMD_SPEED, 8'h5A, 1'b1, 1'b0, 16'h1234, 8'h56, 32'h0, 1'b1, 1'b0, 8'h33, 1'b1},
          1'b0, NO_FRAME},
        '{'{CMD_POSITION, 8'hFF, 1'b1, 1'b1, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b1,
            8'hFF, 1'b1},
          1'b0, NO_FRAME},
        '{'{CMD_POSITION, 8'h00, 1'b0, 1'b0, 16'h0000, 8'h00, 32'h0, 1'b0, 1'b0, 8'h00, 1'b0},
          1'b0, NO_FRAME},
        '{'{CMD_POSITION, 8'h3C, 1'b0, 1'b0, 16'h8001, 8'h80, 32'h8000_0001, 1'b0, 1'b1,
            8'h00, 1'b0},
          1'b0, NO_FRAME},
        '{'{CMD_STOP, 8'h12, 1'b0, 1'b0, 16'h0000, 8'h00, 32'h0, 1'b0, 1'b0, 8'h00, 1'b0},
          1'b1, '{16'h1200, 4'd4, 64'h0000_0000_6B00_98FE, 1'b1, 1'b0}},
        '{'{CMD_STOP, 8'hFF, 1'b1, 1'b1, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b1,
            8'hFF, 1'b1},
          1'b1, '{16'hFF00, 4'd4, 64'h0000_0000_6B01_98FE, 1'b1, 1'b0}},
        // Sync start always goes out on address zero.
        '{'{CMD_SYNC, 8'hFF, 1'b1, 1'b1, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b1,
            8'hFF, 1'b1},
          1'b1, '{16'h0000, 4'd3, 64'h0000_0000_006B_66FF, 1'b1, 1'b0}},
        '{'{CMD_SYNC, 8'h00, 1'b0, 1'b0, 16'h0000, 8'h00, 32'h0, 1'b0, 1'b0, 8'h00, 1'b0},
          1'b1, '{16'h0000, 4'd3, 64'h0000_0000_006B_66FF, 1'b1, 1'b0}},
        '{'{CMD_HOME, 8'h07, 1'b0, 1'b0, 16'h0000, 8'h00, 32'h0, 1'b0, 1'b1, 8'hFF, 1'b0},
          1'b1, '{16'h0700, 4'd4, 64'h0000_0000_6B01_FF9A, 1'b1, 1'b0}},
        '{'{CMD_HOME, 8'hFE, 1'b1, 1'b1, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b0,
            8'h00, 1'b1},
          1'b1, '{16'hFE00, 4'd4, 64'h0000_0000_6B00_009A, 1'b1, 1'b0}},
        '{'{CMD_HOME_PARAMS, 8'h00, 1'b0, 1'b0, 16'h0000, 8'h00, 32'h0, 1'b0, 1'b0,
            8'h00, 1'b0},
          1'b0, NO_FRAME},
        '{'{CMD_HOME_PARAMS, 8'hFF, 1'b1, 1'b1, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b1,
            8'hFF, 1'b1},
          1'b0, NO_FRAME},
        // The unused code is swallowed without a frame.
        '{'{CMD_NONE, 8'hAA, 1'b1, 1'b1, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b1,
            8'hFF, 1'b1},
          1'b0, NO_FRAME},
        '{'{CMD_NONE, 8'h00, 1'b0, 1'b0, 16'h0000, 8'h00, 32'h0, 1'b0, 1'b0, 8'h00, 1'b0},
          1'b0, NO_FRAME},
        '{'{CMD_ENABLE, 8'h55, 1'b1, 1'b0, 16'hA5A5, 8'h5A, 32'h1234_5678, 1'b0, 1'b0,
            8'h3C, 1'b0},
          1'b0, NO_FRAME},
        '{'{CMD_HOME_PARAMS, 8'h81, 1'b0, 1'b1, 16'h0F0F, 8'hC3, 32'h0, 1'b1, 1'b1,
            8'h11, 1'b0},
          1'b0, NO_FRAME}
    };

    // Clock with a 20 ns period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Build the payload of one command and cut it into CAN frames.
    // The frames land in built_frames; the count is returned.
    function automatic int frame_command(input t_cmd_beat c);
        logic [7:0]  pay [0:23];
        logic [7:0]  node;
        logic [15:0] base;
        logic [63:0] d;
        int          n;
        int          nfr;
        int          off;
        int          cnt;
        for (int i = 0; i < 24; i++) pay[i] = 8'h00;
        node = c.addr;
        n    = 0;
        case (c.command)
            CMD_ENABLE: begin
                pay[0] = FN_ENABLE;
                pay[1] = SUB_ENABLE;
                pay[2] = {7'd0, c.enable_on};
                pay[3] = {7'd0, c.sync_flag};
                n = 4;
            end
            CMD_SPEED: begin
                pay[0] = FN_SPEED;
                pay[1] = {7'd0, c.ccw};
                pay[2] = c.rpm[15:8];
                pay[3] = c.rpm[7:0];
                pay[4] = c.accel;
                pay[5] = {7'd0, c.sync_flag};
                n = 6;
            end
            CMD_POSITION: begin
                pay[0]  = FN_POSITION;
                pay[1]  = {7'd0, c.ccw};
                pay[2]  = c.rpm[15:8];
                pay[3]  = c.rpm[7:0];
                pay[4]  = c.accel;
                pay[5]  = c.pulses[31:24];
                pay[6]  = c.pulses[23:16];
                pay[7]  = c.pulses[15:8];
                pay[8]  = c.pulses[7:0];
                pay[9]  = {7'd0, c.absolute_move};
                pay[10] = {7'd0, c.sync_flag};
                n = 11;
            end
            CMD_STOP: begin
                pay[0] = FN_STOP;
                pay[1] = SUB_STOP;
                pay[2] = {7'd0, c.sync_flag};
                n = 3;
            end
            CMD_SYNC: begin
                pay[0] = FN_SYNC;
                pay[1] = SUB_SYNC;
                node   = 8'h00;
                n = 2;
            end
            CMD_HOME: begin
                pay[0] = FN_HOME;
                pay[1] = c.home_kind;
                pay[2] = {7'd0, c.sync_flag};
                n = 3;
            end
            CMD_HOME_PARAMS: begin
                pay[0]  = FN_HOME_PAR;
                pay[1]  = SUB_HOME_PAR;
                pay[2]  = {7'd0, c.save_flag};
                pay[3]  = home_cfg.home_mode_setting;
                pay[4]  = home_cfg.home_direction;
                pay[5]  = home_cfg.home_speed_rpm[15:8];
                pay[6]  = home_cfg.home_speed_rpm[7:0];
                pay[7]  = home_cfg.home_timeout_ms[31:24];
                pay[8]  = home_cfg.home_timeout_ms[23:16];
                pay[9]  = home_cfg.home_timeout_ms[15:8];
                pay[10] = home_cfg.home_timeout_ms[7:0];
                pay[11] = home_cfg.bump_speed_rpm[15:8];
                pay[12] = home_cfg.bump_speed_rpm[7:0];
                pay[13] = home_cfg.bump_current_ma[15:8];
                pay[14] = home_cfg.bump_current_ma[7:0];
                pay[15] = home_cfg.bump_time_ms[15:8];
                pay[16] = home_cfg.bump_time_ms[7:0];
                pay[17] = {7'd0, home_cfg.auto_home_on};
                n = 18;
            end
            default: return 0;
        endcase
        pay[n] = CHECK_BYTE;
        n++;
        base = {node, 8'h00};

        // Short payloads fit one frame as they are.
        if (n <= 8) begin
            d = '0;
            for (int k = 0; k < n; k++) d[8*k +: 8] = pay[k];
            built_frames[0] = '{base, 4'(n), d, 1'b1, 1'b0};
            return 1;
        end

        // Longer ones repeat the function byte ahead of 7-byte chunks.
        nfr = (n - 1 + 6) / 7;
        if (nfr > MAX_FRAMES) begin
            built_frames[0] = '{16'h0000, 4'd0, 64'd0, 1'b1, 1'b1};
            return 1;
        end
        off = 1;
        for (int fi = 0; fi < nfr; fi++) begin
            cnt = (n - off > 7) ? 7 : n - off;
            d = '0;
            d[7:0] = pay[0];
            for (int k = 0; k < cnt; k++) d[8*(k+1) +: 8] = pay[off+k];
            built_frames[fi] = '{base | 16'(fi), 4'(cnt + 1), d, fi == nfr - 1, 1'b0};
            off += cnt;
        end
        return nfr;
    endfunction

    // Write all homing registers back to back and track their masked values.
    task automatic load_home_cfg(input logic [31:0] words [N_REGS]);
        for (int i = 0; i < N_REGS; i++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {t_reg_idx'(i), 2'b00};
            pwdata  <= words[i];
            @(posedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
            case (t_reg_idx'(i))
                REG_HOME_MODE:    home_cfg.home_mode_setting = words[i][7:0];
                REG_HOME_DIR:     home_cfg.home_direction    = words[i][7:0];
                REG_HOME_SPEED:   home_cfg.home_speed_rpm    = words[i][15:0];
                REG_HOME_TIMEOUT: home_cfg.home_timeout_ms   = words[i];
                REG_BUMP_SPEED:   home_cfg.bump_speed_rpm    = words[i][15:0];
                REG_BUMP_CURRENT: home_cfg.bump_current_ma   = words[i][15:0];
                REG_BUMP_TIME:    home_cfg.bump_time_ms      = words[i][15:0];
                REG_AUTO_HOME:    home_cfg.auto_home_on      = words[i][0];
                default: ;
            endcase
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Offer one command beat, after an optional gap, and record its frames
    // once it is accepted. Valid stays high for a following beat.
    task automatic send_beat(input t_cmd_beat b, input logic typed, input t_frame tf);
        int n;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        cmd_ch.valid         <= 1'b1;
        cmd_ch.command       <= b.command;
        cmd_ch.addr          <= b.addr;
        cmd_ch.enable_on     <= b.enable_on;
        cmd_ch.ccw           <= b.ccw;
        cmd_ch.rpm           <= b.rpm;
        cmd_ch.accel         <= b.accel;
        cmd_ch.pulses        <= b.pulses;
        cmd_ch.absolute_move <= b.absolute_move;
        cmd_ch.sync_flag     <= b.sync_flag;
        cmd_ch.home_kind     <= b.home_kind;
        cmd_ch.save_flag     <= b.save_flag;
        do @(posedge i_clk); while (!cmd_ch.ready);
        if (typed) begin
            frames_due.push_back(tf);
        end else begin
            n = frame_command(b);
            for (int i = 0; i < n; i++) frames_due.push_back(built_frames[i]);
        end
    endtask

    // Wait until every owed frame has arrived, then let the block settle.
    task automatic wait_drained();
        while (frames_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_GAP) @(posedge i_clk);
    endtask

    // Receiver pacing: random ready bursts, plus one long hold-off on request.
    initial begin : frame_pacing
        frm_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                frm_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                frm_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end else begin
                frm_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    end

    // Compare each accepted frame beat with the oldest owed frame.
    always @(posedge i_clk) begin : frame_check
        t_frame want;
        if (i_rst_n && frm_ch.valid && frm_ch.ready) begin
            if (frames_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected frame: id %h len %0d data %h last %b err %b",
                             frm_ch.can_id, frm_ch.frame_len, frm_ch.frame_data,
                             frm_ch.last_frame, frm_ch.too_large);
            end else begin
                want = frames_due.pop_front();
                if (frm_ch.can_id !== want.can_id || frm_ch.frame_len !== want.frame_len ||
                    frm_ch.frame_data !== want.frame_data ||
                    frm_ch.last_frame !== want.last_frame ||
                    frm_ch.too_large !== want.too_large) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("frame mismatch, expected: id %h len %0d data %h last %b err %b",
                                 want.can_id, want.frame_len, want.frame_data,
                                 want.last_frame, want.too_large);
                        $display("                  actual: id %h len %0d data %h last %b err %b",
                                 frm_ch.can_id, frm_ch.frame_len, frm_ch.frame_data,
                                 frm_ch.last_frame, frm_ch.too_large);
                    end
                end
            end
        end
    end

    // Main sequence: reset, directed table, then random phases per setting.
    initial begin : stimulus
        logic [31:0] words [N_REGS];
        t_cmd_beat   beat;
        int          pick;
        mismatches   = 0;
        quiet        = 1'b0;
        hold_req     = 1'b0;
        home_cfg     = '0;
        i_rst_n      <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.command       <= '0;
        cmd_ch.addr          <= '0;
        cmd_ch.enable_on     <= 1'b0;
        cmd_ch.ccw           <= 1'b0;
        cmd_ch.rpm           <= '0;
        cmd_ch.accel         <= '0;
        cmd_ch.pulses        <= '0;
        cmd_ch.absolute_move <= 1'b0;
        cmd_ch.sync_flag     <= 1'b0;
        cmd_ch.home_kind     <= '0;
        cmd_ch.save_flag     <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows run on the reset values of the homing registers.
        for (int r = 0; r < N_DIR; r++)
            send_beat(dir_rows[r].beat, dir_rows[r].typed, dir_rows[r].frame);
        cmd_ch.valid <= 1'b0;

        for (int ph = 0; ph < N_PHASES; ph++) begin
            wait_drained();
            // First all ones, then all zeros, then random words.
            for (int i = 0; i < N_REGS; i++) begin
                if (ph == 0)
                    words[i] = 32'hFFFF_FFFF;
                else if (ph == 1)
                    words[i] = 32'h0000_0000;
                else
                    words[i] = $urandom();
            end
            load_home_cfg(words);
            quiet = (ph == N_PHASES - 1);

            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                // Stall the receiver for a long while so the block backs up.
                if (ph == 2 && k == 10) hold_req = 1'b1;
                pick = $urandom_range(0, 19);
                if (pick < 2)
                    beat.command = CMD_ENABLE;
                else if (pick < 5)
                    beat.command = CMD_SPEED;
                else if (pick < 9)
                    beat.command = CMD_POSITION;
                else if (pick < 11)
                    beat.command = CMD_STOP;
                else if (pick < 13)
                    beat.command = CMD_SYNC;
                else if (pick < 15)
                    beat.command = CMD_HOME;
                else if (pick < 19)
                    beat.command = CMD_HOME_PARAMS;
                else
                    beat.command = CMD_NONE;
                beat.addr          = 8'($urandom());
                beat.enable_on     = 1'($urandom());
                beat.ccw           = 1'($urandom());
                beat.rpm           = 16'($urandom());
                beat.accel         = 8'($urandom());
                beat.pulses        = $urandom();
                beat.absolute_move = 1'($urandom());
                beat.sync_flag     = 1'($urandom());
                beat.home_kind     = 8'($urandom());
                beat.save_flag     = 1'($urandom());
                send_beat(beat, 1'b0, NO_FRAME);
            end
            cmd_ch.valid <= 1'b0;
        end

        wait_drained();
        if (mismatches == 0) begin
            $display("stepper_command_can_framer regression: pass");
        end else begin
            $display("stepper_command_can_framer regression: fail");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("stepper_command_can_framer regression: fail");
        $finish;
    end

endmodule
